FILE: hdl/fdec_pkg.sv
`timescale 1ns / 1ps

package fdec_pkg;

    // Default sizes handed to the top level.
    localparam int DEF_TAPS        = 64;
    localparam int DEF_MAX_DECIM   = 16;
    localparam int DEF_SAMPLE_BITS = 16;

    // Fixed field widths.
    localparam int COEF_BITS   = 16;
    localparam int FRAC_BITS   = 15;
    localparam int ACTION_W    = 2;
    localparam int COEF_IDX_W  = 6;
    localparam int DECIM_W     = 5;
    localparam int PHASE_SEL_W = 4;
    localparam int TAP_CNT_W   = 7;

    // Working width for phase arithmetic; it covers the largest decimation field value (31).
    localparam int PHC_W = 7;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] REG_DECIM_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_PHASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT    = 2'd2;

    localparam logic [DECIM_W-1:0]     DECIM_RESET     = 5'd2;
    localparam logic [PHASE_SEL_W-1:0] PHASE_SEL_RESET = 4'd0;
    localparam logic [TAP_CNT_W-1:0]   TAP_CNT_RESET   = 7'd64;

    // Item actions.
    localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DONE
    } fdec_state_t;

    // Controls broadcast to every tap cell.
    typedef struct packed {
        logic                 shift;
        logic                 clear;
        logic                 load;
        logic [TAP_CNT_W-1:0] tap_count;
    } fdec_ctrl_t;

endpackage

FILE: hdl/fdec_in_if.sv
`timescale 1ns / 1ps

interface fdec_in_if #(
    parameter int SAMPLE_BITS = fdec_pkg::DEF_SAMPLE_BITS
);
    logic                                valid;
    logic                                ready;
    logic [fdec_pkg::ACTION_W-1:0]       action;
    logic signed [SAMPLE_BITS-1:0]       sample_in;
    logic [fdec_pkg::COEF_IDX_W-1:0]     coef_index;
    logic signed [fdec_pkg::COEF_BITS-1:0] coef_value;

    modport source (
        output valid, action, sample_in, coef_index, coef_value,
        input  ready
    );

    modport sink (
        input  valid, action, sample_in, coef_index, coef_value,
        output ready
    );
endinterface

FILE: hdl/fdec_out_if.sv
`timescale 1ns / 1ps

interface fdec_out_if #(
    parameter int SAMPLE_BITS = fdec_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    modport source (
        output valid, sample_out,
        input  ready
    );

    modport sink (
        input  valid, sample_out,
        output ready
    );
endinterface

FILE: hdl/fdec_cell.sv
`timescale 1ns / 1ps

module fdec_cell #(
    parameter int SAMPLE_BITS = fdec_pkg::DEF_SAMPLE_BITS,
    parameter int ACC_W       = 40,
    parameter int INDEX       = 0
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fdec_pkg::fdec_ctrl_t                  ctrl,
    input  logic [fdec_pkg::COEF_IDX_W-1:0]       coef_index,
    input  logic signed [fdec_pkg::COEF_BITS-1:0] coef_value,
    input  logic signed [SAMPLE_BITS-1:0]         sample_prev,
    input  logic signed [ACC_W-1:0]               sum_prev,
    output logic signed [SAMPLE_BITS-1:0]         sample_tap,
    output logic signed [ACC_W-1:0]               sum_tap
);

    localparam int PROD_W = SAMPLE_BITS + fdec_pkg::COEF_BITS;

    logic signed [SAMPLE_BITS-1:0]         sample_reg, sample_next;
    logic signed [fdec_pkg::COEF_BITS-1:0] coef_reg, coef_next;
    logic signed [PROD_W-1:0]              prod_reg, prod_next;
    logic signed [ACC_W-1:0]               sum_reg, sum_next;
    logic                                  tap_en;
    logic                                  coef_we;

    // The first tap always counts; the others count while below the tap count.
    assign tap_en  = (INDEX == 0) || (int'(ctrl.tap_count) > INDEX);
    assign coef_we = ctrl.load && (int'(coef_index) == INDEX);

    // Delay line stage: clears, or takes the neighbor's sample on a shift.
    always_comb
    begin
        sample_next = sample_reg;
        if (ctrl.clear)
        begin
            sample_next = '0;
        end
        else if (ctrl.shift)
        begin
            sample_next = sample_prev;
        end
    end

    always_comb
    begin
        coef_next = coef_reg;
        if (coef_we)
        begin
            coef_next = coef_value;
        end
    end

    // Local product, then the running sum passed on to the next cell.
    assign prod_next = sample_reg * coef_reg;
    assign sum_next  = sum_prev + (tap_en ? ACC_W'(prod_reg) : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
        end
        else
        begin
            sample_reg <= sample_next;
        end
    end

    always_ff @(posedge clk)
    begin
        coef_reg <= coef_next;
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
    end

    assign sample_tap = sample_reg;
    assign sum_tap    = sum_reg;

endmodule

FILE: hdl/fir_decimator_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// feed      in         action, sample_in, coef_index, coef_value
// result    out        sample_out
// cfg       in         cfg_we, cfg_index, cfg_data (decim_factor, output_phase, tap_count)
//
// A load, a clear, or a sample that produces no output is taken in the idle state.
// A sample that produces an output holds off the input while the partial
// sum walks the row of tap cells, one cell per cycle, before rounding.
// The output register lets the next beat in while a result waits downstream.
// Reset clears the delay line, phase and handshake state and sets the configuration to its defaults at once.

module fir_decimator_unit #(
    parameter int TAPS        = fdec_pkg::DEF_TAPS,
    parameter int MAX_DECIM   = fdec_pkg::DEF_MAX_DECIM,
    parameter int SAMPLE_BITS = fdec_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    fdec_in_if.sink                             feed,
    fdec_out_if.source                          result,
    input  logic                                cfg_we,
    input  logic [fdec_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fdec_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int ACC_W  = SAMPLE_BITS + fdec_pkg::COEF_BITS + $clog2(TAPS);
    localparam int RND_W  = ACC_W + 1;
    localparam int QW     = RND_W - fdec_pkg::FRAC_BITS;
    localparam int PH_W   = (MAX_DECIM > 1) ? $clog2(MAX_DECIM) : 1;
    localparam int CNT_W  = $clog2(TAPS + 1);
    localparam int PHC_W  = fdec_pkg::PHC_W;

    localparam logic [RND_W-1:0] RND_BIAS  = RND_W'(1) << (fdec_pkg::FRAC_BITS - 1);
    localparam logic [PHC_W-1:0] DECIM_MAX = PHC_W'(MAX_DECIM);
    localparam logic [CNT_W-1:0] CNT_LOAD  = CNT_W'(TAPS);

    // Configuration registers.
    logic [fdec_pkg::DECIM_W-1:0]     decim_reg;
    logic [fdec_pkg::PHASE_SEL_W-1:0] phase_sel_reg;
    logic [fdec_pkg::TAP_CNT_W-1:0]   tap_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decim_reg     <= fdec_pkg::DECIM_RESET;
            phase_sel_reg <= fdec_pkg::PHASE_SEL_RESET;
            tap_count_reg <= fdec_pkg::TAP_CNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fdec_pkg::REG_DECIM_FACTOR:
                    decim_reg <= cfg_data[fdec_pkg::DECIM_W-1:0];
                fdec_pkg::REG_OUTPUT_PHASE:
                    phase_sel_reg <= cfg_data[fdec_pkg::PHASE_SEL_W-1:0];
                fdec_pkg::REG_TAP_COUNT:
                    tap_count_reg <= cfg_data[fdec_pkg::TAP_CNT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Accepted beat decode.
    fdec_pkg::fdec_state_t state_reg, state_next;
    logic                  in_ready;
    logic                  accept;
    logic                  push, clear, load;
    fdec_pkg::fdec_ctrl_t  ctrl;

    assign accept = feed.valid && in_ready;
    assign push   = accept && (feed.action == fdec_pkg::ACT_PUSH);
    assign clear  = accept && (feed.action == fdec_pkg::ACT_CLEAR);
    assign load   = accept && (feed.action == fdec_pkg::ACT_LOAD);

    assign ctrl.shift     = push;
    assign ctrl.clear     = clear;
    assign ctrl.load      = load;
    assign ctrl.tap_count = tap_count_reg;

    // Phase counter with clamped factor and output phase.
    logic [PH_W-1:0]  phase_reg, phase_next;
    logic [PHC_W-1:0] decim_ext, d_eff, ph_sel_ext, ph_eff, phase_ext, phase_inc;
    logic             emit;

    always_comb
    begin
        decim_ext  = PHC_W'(decim_reg);
        ph_sel_ext = PHC_W'(phase_sel_reg);
        phase_ext  = PHC_W'(phase_reg);
        if (decim_ext == '0)
        begin
            d_eff = PHC_W'(1);
        end
        else if (decim_ext > DECIM_MAX)
        begin
            d_eff = DECIM_MAX;
        end
        else
        begin
            d_eff = decim_ext;
        end
        ph_eff    = (ph_sel_ext > d_eff - PHC_W'(1)) ? d_eff - PHC_W'(1) : ph_sel_ext;
        phase_inc = phase_ext + PHC_W'(1);
    end

    assign emit = push && (phase_ext == ph_eff);

    always_comb
    begin
        phase_next = phase_reg;
        if (clear)
        begin
            phase_next = '0;
        end
        else if (push)
        begin
            phase_next = (phase_inc >= d_eff) ? '0 : phase_inc[PH_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // Row of tap cells: samples shift right, partial sums ripple right.
    logic signed [SAMPLE_BITS-1:0] samp_tap [TAPS];
    logic signed [ACC_W-1:0]       sum_tap  [TAPS];

    for (genvar g = 0; g < TAPS; g++)
    begin : g_cell
        logic signed [SAMPLE_BITS-1:0] prev_sample;
        logic signed [ACC_W-1:0]       prev_sum;

        if (g == 0)
        begin : g_head
            assign prev_sample = feed.sample_in;
            assign prev_sum    = '0;
        end
        else
        begin : g_body
            assign prev_sample = samp_tap[g-1];
            assign prev_sum    = sum_tap[g-1];
        end

        fdec_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .ACC_W       (ACC_W),
            .INDEX       (g)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .coef_index  (feed.coef_index),
            .coef_value  (feed.coef_value),
            .sample_prev (prev_sample),
            .sum_prev    (prev_sum),
            .sample_tap  (samp_tap[g]),
            .sum_tap     (sum_tap[g])
        );
    end

    // Sequencer: waits for the sum to cross the row, then hands it to the output.
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             load_out;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fdec_pkg::ST_IDLE:
            begin
                if (emit)
                begin
                    state_next = fdec_pkg::ST_SUM;
                end
            end
            fdec_pkg::ST_SUM:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = fdec_pkg::ST_DONE;
                end
            end
            fdec_pkg::ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = fdec_pkg::ST_IDLE;
                end
            end
            default:
                state_next = fdec_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        load_out = 1'b0;
        cnt_next = cnt_reg;
        case (state_reg)
            fdec_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cnt_next = CNT_LOAD;
            end
            fdec_pkg::ST_SUM:
            begin
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            fdec_pkg::ST_DONE:
            begin
                load_out = !out_valid_reg || result.ready;
            end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fdec_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign feed.ready = in_ready;

    // Round half up, drop the fraction bits and saturate.
    logic [RND_W-1:0]       rnd;
    logic [QW-1:0]          quo;
    logic [SAMPLE_BITS-1:0] sat_value;
    logic [SAMPLE_BITS-1:0] out_data_reg, out_data_next;

    assign rnd = RND_W'(sum_tap[TAPS-1]) + RND_BIAS;
    assign quo = rnd[RND_W-1:fdec_pkg::FRAC_BITS];

    always_comb
    begin
        if ((quo[QW-1:SAMPLE_BITS-1] == '0) || (quo[QW-1:SAMPLE_BITS-1] == '1))
        begin
            sat_value = quo[SAMPLE_BITS-1:0];
        end
        else if (quo[QW-1])
        begin
            sat_value = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            sat_value = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = sat_value;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign result.valid      = out_valid_reg;
    assign result.sample_out = out_data_reg;

    // An emitting sample starts a pass along the row.
    a_emit_starts_sum: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (state_reg == fdec_pkg::ST_SUM) && (cnt_reg == CNT_LOAD))
        else $error("emitting sample did not start a sum pass");

    // The delay line and coefficients stay frozen while a sum is in flight.
    a_frozen_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != fdec_pkg::ST_IDLE) |-> !ctrl.shift && !ctrl.clear && !ctrl.load)
        else $error("tap cells changed during a sum pass");

    // The pass counter steps down by one each cycle.
    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fdec_pkg::ST_SUM) && (cnt_reg != '0)
            |=> (state_reg == fdec_pkg::ST_SUM) && (cnt_reg == $past(cnt_reg) - CNT_W'(1)))
        else $error("sum pass counter skipped");

endmodule
